FILE: sv/single_wire_temp_sensor_reader_defines.svh
// ----------------------------------------------------------------------------
// Single-wire temperature sensor reader: assertion macros
// Clocked assertion helpers. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_TEMP_SENSOR_READER_DEFINES_SVH
`define SINGLE_WIRE_TEMP_SENSOR_READER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property on every edge outside reset
`define SWTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every edge, reset included
`define SWTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWTS_ASSERT(lbl, prop, msg)
`define SWTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/swts_pkg.sv
// ----------------------------------------------------------------------------
// swts_pkg
// Shared types and constants of the single-wire temperature sensor reader.
// ----------------------------------------------------------------------------
package swts_pkg;

  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned BITCNT_W   = 6;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESH   = 2'd3;

  // input kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_HOLD      = 8'b0000_0010,
    PH_START     = 8'b0000_0100,
    PH_RESP_LOW  = 8'b0000_1000,
    PH_RESP_HIGH = 8'b0001_0000,
    PH_RESP_END  = 8'b0010_0000,
    PH_GAP       = 8'b0100_0000,
    PH_PULSE     = 8'b1000_0000
  } swts_phase_t;

  typedef struct packed {
    logic op;
    logic line_level;
  } swts_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] release_high_ticks;
    logic [CNT_W-1:0] start_low_ticks;
    logic [CNT_W-1:0] timeout_ticks;
    logic [THR_W-1:0] bit_threshold_ticks;
  } swts_cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [1:0]               status;
    logic                     done_res;
    logic                     busy_res;
    logic                     drive_low;
  } swts_res_t;

endpackage

FILE: sv/single_wire_temp_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_temp_sensor_reader
// Top level: drives the start sequence of a single-wire sensor and decodes
// its 40-bit frame into a signed temperature in tenths of a degree.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item. in_tuser[0] is the kind (1 = start a reading,
//           0 = one microsecond tick), in_tdata[0] the sampled line level.
//   out_* : exactly one result beat per input beat, in order: drive_low,
//           busy_res, done_res, status and last good temperature.
//   cfg_* : timing registers, written while no beat is in flight.
// An accepted beat waits in the input register; the decoder works on the
// input register and loads the result register, which shows on out_*.
// One beat per cycle while out_tready keeps up; the phase and counter
// update of one tick is a single pass through the decoder.
// Reset clears the state machine to idle, status to ok, temperature to zero
// and loads the timing registers with their defaults.
// When the receiver stalls the result register holds its beat; the input
// register still takes one more beat, then in_tready drops until the
// result register drains.
// ----------------------------------------------------------------------------
`include "single_wire_temp_sensor_reader_defines.svh"

module single_wire_temp_sensor_reader
  import swts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [0] line_level, [7:1] zero
  input  logic                  in_tuser,    // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
  // [20:5] temperature, [23:21] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  swts_cfg_t  cfg;
  swts_item_t item;
  swts_res_t  res;
  logic       item_valid;
  logic       room;
  logic       advance;

  // a held beat moves on when the result register has space
  assign advance = item_valid && room;

  swts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  swts_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  swts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a completed reading leaves the block idle
  `SWTS_ASSERT(a_done_idle, advance && res.done_res |-> !res.busy_res, "done while busy")
  // the start pulse is only driven during a reading
  `SWTS_ASSERT(a_drive_busy, out_tvalid && out_tdata[0] |-> out_tdata[1], "drive while idle")
  // only defined status codes reach the result
  `SWTS_ASSERT(a_status_code, out_tvalid |-> out_tdata[4:3] != 2'd3, "bad status code")
  // a held input beat is not dropped without moving on
  `SWTS_ASSERT(a_item_kept, item_valid && !advance |=> item_valid, "input beat lost")
  // nothing is valid right after reset
  `SWTS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid && !item_valid, "valid after reset")

endmodule

FILE: sv/swts_cfg.sv
// ----------------------------------------------------------------------------
// swts_cfg
// Timing registers, written through the plain configuration port.
// ----------------------------------------------------------------------------
module swts_cfg
  import swts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output swts_cfg_t             cfg
);

  swts_cfg_t cfg_r, cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_RELEASE_HIGH: cfg_nxt.release_high_ticks  = cfg_wdata;
        REG_START_LOW:    cfg_nxt.start_low_ticks     = cfg_wdata;
        REG_TIMEOUT:      cfg_nxt.timeout_ticks       = cfg_wdata;
        REG_BIT_THRESH:   cfg_nxt.bit_threshold_ticks = cfg_wdata[THR_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_high_ticks  <= CNT_W'(10000);
      cfg_r.start_low_ticks     <= CNT_W'(2000);
      cfg_r.timeout_ticks       <= CNT_W'(1000);
      cfg_r.bit_threshold_ticks <= THR_W'(40);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/swts_in_stage.sv
// ----------------------------------------------------------------------------
// swts_in_stage
// Input register: holds one accepted beat until the decoder consumes it.
// ----------------------------------------------------------------------------
module swts_in_stage
  import swts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [0] line_level, rest zero
  input  logic                 in_tuser,   // [0] op
  input  logic                 advance,
  output logic                 item_valid,
  output swts_item_t           item
);

  logic       vld_r, vld_nxt;
  swts_item_t item_r;
  logic       accept;

  // free when empty or when the held beat moves on this cycle
  assign in_tready = !vld_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op         <= in_tuser;
      item_r.line_level <= in_tdata[0];
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

FILE: sv/swts_fsm.sv
// ----------------------------------------------------------------------------
// swts_fsm
// Read-sequence FSM: one beat per cycle unless stalled, frame decode on last bit.
// ----------------------------------------------------------------------------
module swts_fsm
  import swts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  swts_item_t item,
  input  swts_cfg_t  cfg,
  output swts_res_t  res
);

  swts_phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [BITCNT_W-1:0]      bits_r, bits_nxt;
  logic [FRAME_BITS-1:0]    frame_r, frame_nxt;
  logic [1:0]               status_r, status_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;

  logic                  done;
  logic                  tmo;
  logic                  wait_over;
  logic [CNT_W:0]        cnt_inc;
  logic                  bit_val;
  logic [FRAME_BITS-1:0] frame_sh;
  logic [BITCNT_W-1:0]   bits_inc;
  logic [7:0]            b0, b1, b2, b3, b4, sum;
  logic [TEMP_W-1:0]     mag;

  assign cnt_inc   = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign wait_over = (cnt_r >= cfg.timeout_ticks);
  assign bit_val   = (cnt_r > CNT_W'(cfg.bit_threshold_ticks));
  assign frame_sh  = {frame_r[FRAME_BITS-2:0], bit_val};
  assign bits_inc  = bits_r + BITCNT_W'(1);

  // checksum and sign-magnitude decode of the shifted frame
  assign b0  = frame_sh[39:32];
  assign b1  = frame_sh[31:24];
  assign b2  = frame_sh[23:16];
  assign b3  = frame_sh[15:8];
  assign b4  = frame_sh[7:0];
  assign sum = b0 + b1 + b2 + b3;
  assign mag = {1'b0, b2[6:0], b3};

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    bits_nxt   = bits_r;
    frame_nxt  = frame_r;
    status_nxt = status_r;
    temp_nxt   = temp_r;
    done       = 1'b0;
    tmo        = 1'b0;
    if (item.op == OP_START) begin
      phase_nxt = PH_HOLD;
      cnt_nxt   = '0;
      bits_nxt  = '0;
      frame_nxt = '0;
    end else begin
      case (phase_r)
        PH_HOLD: begin
          if (cnt_inc >= {1'b0, cfg.release_high_ticks}) begin
            phase_nxt = PH_START;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        PH_START: begin
          if (cnt_inc >= {1'b0, cfg.start_low_ticks}) begin
            phase_nxt = PH_RESP_LOW;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        PH_RESP_LOW, PH_RESP_END: begin
          if (item.line_level) begin
            tmo     = wait_over;
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end else begin
            phase_nxt = (phase_r == PH_RESP_LOW) ? PH_RESP_HIGH : PH_GAP;
            cnt_nxt   = '0;
          end
        end
        PH_RESP_HIGH, PH_GAP: begin
          if (!item.line_level) begin
            tmo     = wait_over;
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end else begin
            phase_nxt = (phase_r == PH_RESP_HIGH) ? PH_RESP_END : PH_PULSE;
            cnt_nxt   = '0;
          end
        end
        PH_PULSE: begin
          if (item.line_level) begin
            tmo     = wait_over;
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end else begin
            frame_nxt = frame_sh;
            bits_nxt  = bits_inc;
            cnt_nxt   = '0;
            if (bits_inc >= BITCNT_W'(FRAME_BITS)) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              if (b4 != sum) begin
                status_nxt = ST_CHECKSUM;
              end else begin
                status_nxt = ST_OK;
                temp_nxt   = b2[7] ? $signed(TEMP_W'(0) - mag) : $signed(mag);
              end
            end else begin
              phase_nxt = PH_GAP;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      // any expired edge wait ends the reading
      if (tmo) begin
        status_nxt = ST_TIMEOUT;
        phase_nxt  = PH_IDLE;
        cnt_nxt    = '0;
        done       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      bits_r   <= '0;
      frame_r  <= '0;
      status_r <= ST_OK;
      temp_r   <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      bits_r   <= bits_nxt;
      frame_r  <= frame_nxt;
      status_r <= status_nxt;
      temp_r   <= temp_nxt;
    end
  end

  // result of the beat being consumed
  assign res.drive_low   = (phase_nxt == PH_START);
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.done_res    = done;
  assign res.status      = status_nxt;
  assign res.temperature = temp_nxt;

endmodule

FILE: sv/swts_out_stage.sv
// ----------------------------------------------------------------------------
// swts_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module swts_out_stage
  import swts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  swts_res_t             res,
  output logic                  room,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
  // [20:5] temperature, [23:21] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic      vld_r, vld_nxt;
  swts_res_t res_r;

  assign room = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {(OUT_DATA_W-$bits(swts_res_t))'(0), res_r};

endmodule

FILE: dv/tb_single_wire_temp_sensor_reader.sv
// ----------------------------------------------------------------------------
// Single-wire temperature sensor reader testbench
// Feeds start commands and microsecond line samples, mostly shaped as full
// sensor frames (good, bad checksum, stretched edges, aborted), and checks
// every result beat against a cycle-free model of the read sequence.
// ----------------------------------------------------------------------------
module tb_single_wire_temp_sensor_reader;
  import swts_pkg::*;

  localparam int unsigned PHASE_BEATS     = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  typedef enum int {RD_GOOD, RD_BAD_SUM, RD_TIMEOUT, RD_ABORT} reading_kind_t;

  // Model of the read sequence plus the queue of readouts still owed
  class readout_scoreboard;
    swts_cfg_t               timing;
    swts_phase_t             ph;
    logic [CNT_W-1:0]        ticks;
    logic [BITCNT_W-1:0]     nbits;
    logic [FRAME_BITS-1:0]   frame;
    logic [1:0]              status;
    logic signed [TEMP_W-1:0] temp;
    swts_res_t               pending_readouts[$];
    int unsigned             errors, n_ok, n_timeout, n_badsum, n_below_zero;

    function new();
      timing.release_high_ticks  = 20'd10000;
      timing.start_low_ticks     = 20'd2000;
      timing.timeout_ticks       = 20'd1000;
      timing.bit_threshold_ticks = 10'd40;
      ph     = PH_IDLE;
      ticks  = '0;
      nbits  = '0;
      frame  = '0;
      status = ST_OK;
      temp   = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RELEASE_HIGH: timing.release_high_ticks  = val;
        REG_START_LOW:    timing.start_low_ticks     = val;
        REG_TIMEOUT:      timing.timeout_ticks       = val;
        REG_BIT_THRESH:   timing.bit_threshold_ticks = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the model by one accepted input beat and queue its readout
    function void predict_readout(logic op, logic lvl);
      logic              done, tmo, waiting;
      logic [7:0]        sum;
      logic [TEMP_W-1:0] mag;
      swts_res_t         r;
      done = 1'b0;
      tmo  = 1'b0;
      if (op == OP_START) begin
        ph    = PH_HOLD;
        ticks = '0;
        nbits = '0;
        frame = '0;
      end else begin
        case (ph)
          PH_HOLD: begin
            if (ticks + 32'd1 >= timing.release_high_ticks) begin
              ph    = PH_START;
              ticks = '0;
            end else begin
              ticks++;
            end
          end
          PH_START: begin
            if (ticks + 32'd1 >= timing.start_low_ticks) begin
              ph    = PH_RESP_LOW;
              ticks = '0;
            end else begin
              ticks++;
            end
          end
          PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END, PH_GAP, PH_PULSE: begin
            // response-high and gap wait out a low line, the others a high one
            waiting = (ph == PH_RESP_HIGH || ph == PH_GAP) ? !lvl : lvl;
            if (waiting) begin
              if (ticks >= timing.timeout_ticks) tmo = 1'b1;
              else ticks++;
            end else begin
              case (ph)
                PH_RESP_LOW:  ph = PH_RESP_HIGH;
                PH_RESP_HIGH: ph = PH_RESP_END;
                PH_RESP_END:  ph = PH_GAP;
                PH_GAP:       ph = PH_PULSE;
                default: begin
                  // falling edge closes a data pulse
                  frame = {frame[FRAME_BITS-2:0], ticks > timing.bit_threshold_ticks};
                  nbits++;
                  ph = PH_GAP;
                  if (nbits >= FRAME_BITS) begin
                    sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                    if (frame[7:0] != sum) begin
                      status = ST_CHECKSUM;
                      n_badsum++;
                    end else begin
                      // sign-magnitude tenths; negative zero reads as zero
                      mag    = {1'b0, frame[22:8]};
                      status = ST_OK;
                      temp   = frame[23] ? -mag : mag;
                      n_ok++;
                      if (frame[23] && mag != 0) n_below_zero++;
                    end
                    ph   = PH_IDLE;
                    done = 1'b1;
                  end
                end
              endcase
              ticks = '0;
            end
          end
          default: ph = PH_IDLE;
        endcase
        if (tmo) begin
          status = ST_TIMEOUT;
          ph     = PH_IDLE;
          ticks  = '0;
          done   = 1'b1;
          n_timeout++;
        end
      end
      r.drive_low   = (ph == PH_START);
      r.busy_res    = (ph != PH_IDLE);
      r.done_res    = done;
      r.status      = status;
      r.temperature = temp;
      pending_readouts.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_readout(logic [OUT_DATA_W-1:0] data);
      swts_res_t got, want;
      got = data[$bits(swts_res_t)-1:0];
      if (pending_readouts.size() == 0) begin
        $error("result beat with nothing outstanding: %h", data);
        errors++;
      end else begin
        want = pending_readouts.pop_front();
        check_field("drive_low", want.drive_low, got.drive_low);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("status", want.status, got.status);
        check_field("temperature", want.temperature, got.temperature);
      end
    endfunction

    function int unsigned pending();
      return pending_readouts.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [0] line_level
  logic                  in_tuser   = 1'b0; // [0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [20:5] temperature
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  readout_scoreboard sb = new();
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_off_req  = 1'b0;
  int unsigned n_beats       = 0;
  int unsigned n_aborts      = 0;

  always #5 clk = ~clk;

  single_wire_temp_sensor_reader u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink_proc
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
      @(posedge clk);
    end
  end

  // check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_readout(out_tdata);
  end

  // end the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // offer one input beat after a random gap; valid stays up until a gap
  task automatic send_beat(input logic op, input logic lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_readout(op, lvl);
    n_beats++;
  endtask

  task automatic emit_level(input logic lvl, input int n);
    repeat (n) send_beat(OP_TICK, lvl);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_timing(input swts_cfg_t c);
    write_reg(REG_RELEASE_HIGH, c.release_high_ticks);
    write_reg(REG_START_LOW, c.start_low_ticks);
    write_reg(REG_TIMEOUT, c.timeout_ticks);
    write_reg(REG_BIT_THRESH, CFG_DATA_W'(c.bit_threshold_ticks));
  endtask

  // drop valid and let every owed readout come back
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one read sequence as the sensor would answer it, with an optional fault
  task automatic read_sensor(input reading_kind_t kind);
    logic [7:0]            b0, b1, b2, b3, b4;
    logic [FRAME_BITS-1:0] bits;
    logic                  lvl;
    int                    t, thr, seg_max, w0_max, lo_max, fault_seg, n;
    t       = sb.timing.timeout_ticks;
    thr     = sb.timing.bit_threshold_ticks;
    seg_max = (t + 1 < 3) ? t + 1 : 3;
    w0_max  = (t < 2) ? t : 2;
    lo_max  = (thr + 1 < seg_max) ? thr + 1 : seg_max;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    b3 = 8'($urandom);
    if ($urandom_range(9) == 0) begin
      b2 = 8'h80;
      b3 = 8'h00;
    end
    b4 = b0 + b1 + b2 + b3;
    if (kind == RD_BAD_SUM) b4 = b4 + 8'($urandom_range(255, 1));
    bits      = {b0, b1, b2, b3, b4};
    fault_seg = $urandom_range(2 * FRAME_BITS + 2, 0);

    send_beat(OP_START, 1'($urandom_range(1)));
    repeat (sb.timing.release_high_ticks + sb.timing.start_low_ticks)
      send_beat(OP_TICK, 1'($urandom_range(1)));
    // segments: pre-high, response low, response high, then gap/pulse pairs
    for (int seg = 0; seg < 3 + 2 * FRAME_BITS; seg++) begin
      lvl = (seg % 2 == 0);
      if (seg == fault_seg && kind == RD_TIMEOUT) begin
        emit_level(lvl, t + 2);
        return;
      end
      if (seg == fault_seg && kind == RD_ABORT) begin
        send_beat(OP_START, 1'($urandom_range(1)));
        n_aborts++;
        return;
      end
      if (seg == 0) n = $urandom_range(w0_max, 0);
      else if (seg < 3 || !lvl) n = $urandom_range(seg_max, 1);
      else if (bits[FRAME_BITS - 1 - (seg - 4) / 2] && thr + 2 <= t + 1 && thr + 2 <= 8)
        n = thr + 2 + ((thr + 3 <= t + 1) ? $urandom_range(1) : 0);
      else n = $urandom_range(lo_max, 1);
      emit_level(lvl, n);
    end
    emit_level(1'b0, 1);
  endtask

  initial begin : stimulus
    int unsigned src_tab[5]  = '{0, 56, 0, 35, 0};
    int unsigned sink_tab[5] = '{0, 0, 56, 35, 0};
    swts_cfg_t   c;
    int unsigned first, pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: largest timings, idle ticks, start and restart in hold,
    // shrinking the timings mid-sequence, then a response timeout
    c.release_high_ticks  = '1;
    c.start_low_ticks     = '1;
    c.timeout_ticks       = '1;
    c.bit_threshold_ticks = '1;
    program_timing(c);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    wait_quiet();
    write_reg(REG_RELEASE_HIGH, 20'd1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    wait_quiet();
    write_reg(REG_START_LOW, 20'd1);
    emit_level(1'b1, 4);
    wait_quiet();
    write_reg(REG_TIMEOUT, 20'd1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);

    // random frames under each throttle pattern; the last phase runs one
    // reading with the largest threshold and timeout
    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      src_idle_pct   = src_tab[p];
      sink_stall_pct = sink_tab[p];
      if (p == 0) begin
        c = '{release_high_ticks: CNT_W'(1), start_low_ticks: CNT_W'(1),
              timeout_ticks: CNT_W'(2), bit_threshold_ticks: THR_W'(1)};
      end else if (p == 4) begin
        c.release_high_ticks  = CNT_W'($urandom_range(3, 1));
        c.start_low_ticks     = CNT_W'($urandom_range(3, 1));
        c.timeout_ticks       = '1;
        c.bit_threshold_ticks = '1;
      end else begin
        c.release_high_ticks  = CNT_W'($urandom_range(4, 1));
        c.start_low_ticks     = CNT_W'($urandom_range(4, 1));
        c.bit_threshold_ticks = THR_W'($urandom_range(3, 1));
        c.timeout_ticks       = CNT_W'($urandom_range(8, c.bit_threshold_ticks + 1));
      end
      program_timing(c);
      if (p == 0) hold_off_req = 1'b1;
      first = n_beats;
      do begin
        pick = $urandom_range(99);
        if (p == 4) read_sensor(RD_GOOD);
        else if (pick < 12) begin
          // stray beats: idle ticks or a start dropped in anywhere
          repeat ($urandom_range(4, 1))
            send_beat(($urandom_range(9) == 0) ? OP_START : OP_TICK, 1'($urandom_range(1)));
        end
        else if (pick < 60) read_sensor(RD_GOOD);
        else if (pick < 75) read_sensor(RD_BAD_SUM);
        else if (pick < 90) read_sensor(RD_TIMEOUT);
        else read_sensor(RD_ABORT);
      end while (p != 4 && n_beats - first < PHASE_BEATS);
    end

    wait_quiet();
    $display("%0d beats: %0d good readings (%0d below zero), %0d timeouts, %0d bad checksums",
             n_beats, sb.n_ok, sb.n_below_zero, sb.n_timeout, sb.n_badsum);
    $display("%0d restarts mid-frame; throttle phases plus one %0d-cycle result hold-off",
             n_aborts, HOLD_OFF_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
